[src/smoothed_drive_tanh_saturator_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the drive-smoothed tanh saturator
// Concurrent check helpers for the assertions of the top-level unit.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_DRIVE_TANH_SATURATOR_UNIT_DEFINES_SVH
`define SMOOTHED_DRIVE_TANH_SATURATOR_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define SDTS_CHECK(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdts: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define SDTS_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdts: next-cycle check failed");

`endif

[src/sdts_pkg.sv]
// ----------------------------------------------------------------------------
// sdts_pkg
// Types, widths, codes and the tanh table generator of the saturator.
// ----------------------------------------------------------------------------
`default_nettype none

package sdts_pkg;

   localparam int SAMPLE_W     = 24;
   localparam int LANES        = 2;
   localparam int CHANNELS     = 2;
   localparam int TDATA_W      = LANES * SAMPLE_W;
   localparam int DRIVE_W      = 17;
   localparam int LENGTH_W     = 16;
   localparam int DRIVE_FRAC_W = 16;
   localparam int CUR_W        = 33;
   localparam int STEP_W       = 34;
   localparam int DIV_STEPS    = 33;
   localparam int DIV_CNT_W    = 6;
   localparam int TANH_W       = 30;
   localparam int FRAC_W       = 23;
   localparam int SLOPE_W      = 31;
   localparam int PROD_W       = 55;
   localparam int SHAPE_W      = 32;
   localparam int X31_W        = 32;
   localparam int DELTA_W      = 33;
   localparam int MIX_W        = 51;
   localparam int ROUND_W      = 36;
   localparam int OUT_SHIFT    = 8;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = 1;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [DRIVE_W-1:0]  FULL_DRIVE        = 17'd65536;
   localparam logic [LENGTH_W-1:0] RAMP_LENGTH_RESET = 16'd2400;
   localparam logic [CUR_W-1:0]    DRIVE_HALF        = 33'd32768;
   localparam logic signed [MIX_W-1:0]   MIX_HALF   = 51'sd32768;
   localparam logic signed [ROUND_W-1:0] OUT_HALF   = 36'sd128;
   localparam logic signed [ROUND_W-1:0] SAT_HIGH   = 36'sd8388607;
   localparam logic signed [ROUND_W-1:0] SAT_LOW    = -36'sd8388608;

   localparam longint unsigned ONE_Q31 = 64'd1 << 31;

   typedef enum logic [0:0] {
      REG_DRIVE_TARGET = 1'b0,
      REG_RAMP_LENGTH  = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_DIVIDE,
      FR_SIGN,
      FR_ADVANCE,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_POS,
      BK_LUT,
      BK_SLOPE,
      BK_SHAPE,
      BK_BLEND,
      BK_FINISH
   } back_state_type;

   typedef logic [LANES-1:0][SAMPLE_W-1:0] frame_type;

   typedef struct packed {
      logic [DRIVE_W-1:0]  drive_target;
      logic [LENGTH_W-1:0] ramp_length;
   } csr_type;

   typedef struct packed {
      frame_type          sample;
      logic [DRIVE_W-1:0] drive;
   } entry_type;

   // Shift-subtract quotient, used only while elaborating the table.
   function automatic longint unsigned sdts_udiv(input longint unsigned num,
                                                 input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = (rem << 1) | longint'(num[b]);
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tanh(3a)/3 in Q0.31 for a = idx / (points - 1). exp(-6a/64) comes from a
   // series up to the eighth power and is squared six times to reach exp(-6a).
   function automatic logic [TANH_W-1:0] tanh_entry(input int unsigned idx,
                                                   input int unsigned points);
      longint unsigned span;
      longint unsigned w;
      longint unsigned term;
      longint unsigned e;
      longint unsigned t;
      span = (points > 1) ? longint'(points - 1) : 64'd1;
      w    = sdts_udiv(64'd201326592 * longint'(idx) + (span >> 1), span);
      term = ONE_Q31;
      e    = ONE_Q31;
      for (int k = 1; k <= 8; k++) begin
         term = sdts_udiv((term * w) >> 31, longint'(k));
         e    = (k % 2 == 1) ? e - term : e + term;
      end
      for (int r = 0; r < 6; r++) begin
         e = (e * e + (64'd1 << 30)) >> 31;
      end
      t = sdts_udiv((ONE_Q31 - e) << 31, ONE_Q31 + e);
      return TANH_W'(sdts_udiv(t, 64'd3));
   endfunction

endpackage

`default_nettype wire

[src/sdts_front.sv]
// ----------------------------------------------------------------------------
// sdts_front
// Takes frames, moves the drive ramp one frame on and queues frame plus drive.
// ----------------------------------------------------------------------------
`default_nettype none

module sdts_front
   import sdts_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire csr_type            cfg,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [TDATA_W-1:0] req_tdata,
   output logic                    push_valid,
   output entry_type               push_data,
   input  wire logic               queue_full
);

   front_state_type state_ff, state_in;

   frame_type                   sample_ff, sample_in;
   logic [CUR_W-1:0]            current_ff, current_in;
   logic signed [STEP_W-1:0]    step_ff, step_in;
   logic [LENGTH_W-1:0]         remaining_ff, remaining_in;
   logic [DRIVE_W-1:0]          goal_ff, goal_in;
   logic [DIV_CNT_W-1:0]        div_cnt_ff, div_cnt_in;
   logic [LENGTH_W-1:0]         div_rem_ff, div_rem_in;
   logic [CUR_W-1:0]            div_quo_ff, div_quo_in;
   logic                        div_neg_ff, div_neg_in;

   logic                        accept_w;
   logic [DRIVE_W-1:0]          target_w;
   logic signed [STEP_W-1:0]    diff_w;
   logic signed [STEP_W-1:0]    neg_diff_w;
   logic [CUR_W-1:0]            mag_w;
   logic                        retarget_w;
   logic                        start_div_w;
   logic [LENGTH_W:0]           rem_shift_w;
   logic                        div_ge_w;
   logic signed [STEP_W-1:0]    advanced_w;
   logic [CUR_W-1:0]            rounded_w;

   assign accept_w    = req_tvalid && req_tready;
   assign target_w    = (cfg.drive_target > FULL_DRIVE) ? FULL_DRIVE : cfg.drive_target;
   assign diff_w      = $signed({1'b0, target_w, {DRIVE_FRAC_W{1'b0}}})
                        - $signed({1'b0, current_ff});
   assign neg_diff_w  = -diff_w;
   assign mag_w       = diff_w[STEP_W-1] ? neg_diff_w[CUR_W-1:0] : diff_w[CUR_W-1:0];
   assign retarget_w  = (target_w != goal_ff);
   assign start_div_w = retarget_w && (cfg.ramp_length != '0);
   assign rem_shift_w = {div_rem_ff, div_quo_ff[CUR_W-1]};
   assign div_ge_w    = (rem_shift_w >= {1'b0, cfg.ramp_length});
   assign advanced_w  = $signed({1'b0, current_ff}) + step_ff;
   assign rounded_w   = current_ff + DRIVE_HALF;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (accept_w) begin
               state_in = start_div_w ? FR_DIVIDE : FR_ADVANCE;
            end
         end
         FR_DIVIDE: begin
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = FR_SIGN;
            end
         end
         FR_SIGN:    state_in = FR_ADVANCE;
         FR_ADVANCE: state_in = FR_PUSH;
         FR_PUSH: begin
            if (!queue_full) begin
               state_in = FR_IDLE;
            end
         end
         default:    state_in = FR_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready       = (state_ff == FR_IDLE);
      push_valid       = (state_ff == FR_PUSH);
      push_data.sample = sample_ff;
      push_data.drive  = rounded_w[CUR_W-1:DRIVE_FRAC_W];
   end

   // Ramp and divider datapath
   always_comb begin
      sample_in    = sample_ff;
      current_in   = current_ff;
      step_in      = step_ff;
      remaining_in = remaining_ff;
      goal_in      = goal_ff;
      div_cnt_in   = div_cnt_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_neg_in   = div_neg_ff;
      case (state_ff)
         FR_IDLE: begin
            if (accept_w) begin
               sample_in = frame_type'(req_tdata);
               if (retarget_w) begin
                  goal_in = target_w;
                  if (cfg.ramp_length == '0) begin
                     current_in   = {target_w, {DRIVE_FRAC_W{1'b0}}};
                     remaining_in = '0;
                  end else begin
                     remaining_in = cfg.ramp_length;
                     div_neg_in   = diff_w[STEP_W-1];
                     div_quo_in   = mag_w;
                     div_rem_in   = '0;
                     div_cnt_in   = '0;
                  end
               end
            end
         end
         FR_DIVIDE: begin
            // The partial remainder stays below the ramp length while that length is held.
            div_rem_in = div_ge_w ? LENGTH_W'(rem_shift_w - {1'b0, cfg.ramp_length})
                                  : rem_shift_w[LENGTH_W-1:0];
            div_quo_in = {div_quo_ff[CUR_W-2:0], div_ge_w};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         FR_SIGN: begin
            step_in = div_neg_ff ? -$signed({1'b0, div_quo_ff}) : $signed({1'b0, div_quo_ff});
         end
         FR_ADVANCE: begin
            if (remaining_ff != '0) begin
               remaining_in = remaining_ff - LENGTH_W'(1);
               if (remaining_ff == LENGTH_W'(1)) begin
                  current_in = {goal_ff, {DRIVE_FRAC_W{1'b0}}};
               end else begin
                  current_in = advanced_w[CUR_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FR_IDLE;
         current_ff   <= '0;
         step_ff      <= '0;
         remaining_ff <= '0;
         goal_ff      <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         current_ff   <= current_in;
         step_ff      <= step_in;
         remaining_ff <= remaining_in;
         goal_ff      <= goal_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_neg_ff <= div_neg_in;
   end

endmodule

`default_nettype wire

[src/sdts_queue.sv]
// ----------------------------------------------------------------------------
// sdts_queue
// Two-entry queue of frames with their drive between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sdts_queue
   import sdts_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  wire entry_type push_data,
   output logic           queue_full,
   input  wire logic      pop,
   output entry_type      pop_data,
   output logic           queue_empty
);

   entry_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     do_push_w;
   logic                     do_pop_w;

   assign queue_full  = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign do_push_w   = push_valid && !queue_full;
   assign do_pop_w    = pop && !queue_empty;
   assign pop_data    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push_w) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop_w) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push_w && !do_pop_w) begin
         count_in = count_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (do_pop_w && !do_push_w) begin
         count_in = count_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push_w) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/sdts_back.sv]
// ----------------------------------------------------------------------------
// sdts_back
// Table lookup, interpolation, drive blend and saturation for each channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sdts_back
   import sdts_pkg::*;
#(
   parameter int TANH_TABLE_POINTS = 256
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire entry_type          pop_data,
   input  wire logic               queue_empty,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [TDATA_W-1:0]      rsp_tdata
);

   localparam int IDX_W = $clog2(TANH_TABLE_POINTS);
   localparam int POS_W = FRAC_W + IDX_W;
   localparam logic [IDX_W-1:0] SPAN = IDX_W'(TANH_TABLE_POINTS - 1);

   back_state_type state_ff, state_in;

   logic [TANH_W-1:0] lut_w [TANH_TABLE_POINTS];

   for (genvar g = 0; g < TANH_TABLE_POINTS; g++) begin : g_lut
      localparam logic [TANH_W-1:0] ENTRY = tanh_entry(g, TANH_TABLE_POINTS);
      assign lut_w[g] = ENTRY;
   end

   logic signed [SAMPLE_W-1:0] x_ff     [LANES];
   logic signed [SAMPLE_W-1:0] x_in     [LANES];
   logic [SAMPLE_W-1:0]        ax_ff    [LANES];
   logic [SAMPLE_W-1:0]        ax_in    [LANES];
   logic [POS_W-1:0]           pos_ff   [LANES];
   logic [POS_W-1:0]           pos_in   [LANES];
   logic [TANH_W-1:0]          t0_ff    [LANES];
   logic [TANH_W-1:0]          t0_in    [LANES];
   logic signed [SLOPE_W-1:0]  slope_ff [LANES];
   logic signed [SLOPE_W-1:0]  slope_in [LANES];
   logic [FRAC_W-1:0]          frac_ff  [LANES];
   logic [FRAC_W-1:0]          frac_in  [LANES];
   logic signed [PROD_W-1:0]   prod_ff  [LANES];
   logic signed [PROD_W-1:0]   prod_in  [LANES];
   logic signed [DELTA_W-1:0]  delta_ff [LANES];
   logic signed [DELTA_W-1:0]  delta_in [LANES];
   logic signed [MIX_W-1:0]    mix_ff   [LANES];
   logic signed [MIX_W-1:0]    mix_in   [LANES];
   logic [DRIVE_W-1:0]         d16_ff, d16_in;
   frame_type                  out_ff, out_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]           idx_w    [LANES];
   logic [IDX_W-1:0]           nxt_w    [LANES];
   logic signed [SHAPE_W-1:0]  shape_w  [LANES];
   logic signed [SHAPE_W-1:0]  hs_w     [LANES];
   logic signed [X31_W-1:0]    x31_w    [LANES];
   logic signed [ROUND_W-1:0]  rnd_w    [LANES];
   logic signed [ROUND_W-1:0]  y31_w    [LANES];
   logic signed [ROUND_W-1:0]  y_w      [LANES];
   logic                       load_w;

   assign load_w     = (state_ff == BK_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               state_in = BK_POS;
            end
         end
         BK_POS:   state_in = BK_LUT;
         BK_LUT:   state_in = BK_SLOPE;
         BK_SLOPE: state_in = BK_SHAPE;
         BK_SHAPE: state_in = BK_BLEND;
         BK_BLEND: state_in = BK_FINISH;
         BK_FINISH: begin
            if (load_w) begin
               state_in = BK_IDLE;
            end
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      pop = (state_ff == BK_IDLE) && !queue_empty;
   end

   // Per-channel datapath; the stage registers run freely and the sequencer
   // only decides when a frame is taken in and when its result is kept.
   always_comb begin
      d16_in       = pop ? pop_data.drive : d16_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      if (load_w) begin
         rsp_valid_in = 1'b1;
      end
      for (int ln = 0; ln < LANES; ln++) begin
         x_in[ln]  = pop ? $signed(pop_data.sample[ln]) : x_ff[ln];
         ax_in[ln] = x_in[ln][SAMPLE_W-1] ? SAMPLE_W'(-x_in[ln]) : SAMPLE_W'(x_in[ln]);
         if (!pop) begin
            ax_in[ln] = ax_ff[ln];
         end

         pos_in[ln] = POS_W'(ax_ff[ln]) * POS_W'(SPAN);

         idx_w[ln]   = pos_ff[ln][POS_W-1:FRAC_W];
         nxt_w[ln]   = (idx_w[ln] == SPAN) ? idx_w[ln] : idx_w[ln] + IDX_W'(1);
         frac_in[ln] = pos_ff[ln][FRAC_W-1:0];
         t0_in[ln]   = lut_w[idx_w[ln]];
         slope_in[ln] = (idx_w[ln] == SPAN) ? '0
                        : $signed({1'b0, lut_w[nxt_w[ln]]}) - $signed({1'b0, lut_w[idx_w[ln]]});

         prod_in[ln] = slope_ff[ln] * $signed({1'b0, frac_ff[ln]});

         shape_w[ln] = $signed({2'b00, t0_ff[ln]}) + SHAPE_W'(prod_ff[ln] >>> FRAC_W);
         hs_w[ln]    = x_ff[ln][SAMPLE_W-1] ? -shape_w[ln] : shape_w[ln];
         x31_w[ln]   = $signed({x_ff[ln], {OUT_SHIFT{1'b0}}});
         delta_in[ln] = DELTA_W'(hs_w[ln]) - DELTA_W'(x31_w[ln]);

         mix_in[ln] = delta_ff[ln] * $signed({1'b0, d16_ff});

         rnd_w[ln] = ROUND_W'((mix_ff[ln] + MIX_HALF) >>> DRIVE_FRAC_W);
         y31_w[ln] = ROUND_W'(x31_w[ln]) + rnd_w[ln];
         y_w[ln]   = (y31_w[ln] + OUT_HALF) >>> OUT_SHIFT;
         if (load_w) begin
            if (ln >= CHANNELS) begin
               out_in[ln] = x_ff[ln];
            end else if (y_w[ln] > SAT_HIGH) begin
               out_in[ln] = SAMPLE_W'(SAT_HIGH);
            end else if (y_w[ln] < SAT_LOW) begin
               out_in[ln] = SAMPLE_W'(SAT_LOW);
            end else begin
               out_in[ln] = SAMPLE_W'(y_w[ln]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d16_ff <= d16_in;
      out_ff <= out_in;
      for (int ln = 0; ln < LANES; ln++) begin
         x_ff[ln]     <= x_in[ln];
         ax_ff[ln]    <= ax_in[ln];
         pos_ff[ln]   <= pos_in[ln];
         t0_ff[ln]    <= t0_in[ln];
         slope_ff[ln] <= slope_in[ln];
         frac_ff[ln]  <= frac_in[ln];
         prod_ff[ln]  <= prod_in[ln];
         delta_ff[ln] <= delta_in[ln];
         mix_ff[ln]   <= mix_in[ln];
      end
   end

endmodule

`default_nettype wire

[src/smoothed_drive_tanh_saturator_unit.sv]
// ----------------------------------------------------------------------------
// smoothed_drive_tanh_saturator_unit
// Stereo tanh soft clipper with a linearly ramped dry/wet drive blend.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Contents
//   req_*     in         tvalid/tready         one stereo frame, Q1.23 samples
//   rsp_*     out        tvalid/tready         processed frame, saturated
//   csr_*     in/out     psel/penable/pready   drive_target (0x0), ramp_length (0x4)
//
// The front takes a new frame only after queueing the last one. A change of
// target with a nonzero ramp length adds a divide state, which forms the ramp
// step quotient one bit per cycle, and a sign state. The back runs each frame
// through its chain of three registered multiplications and takes the next
// only after the result is loaded. Reset is synchronous: the drive returns to
// zero, the ramp length to 2400 and the queue empties. A held result transfer
// stalls only the back; the front fills the two-entry queue and holds one more.
// ----------------------------------------------------------------------------
`default_nettype none

`include "smoothed_drive_tanh_saturator_unit_defines.svh"

module smoothed_drive_tanh_saturator_unit
   import sdts_pkg::*;
#(
   parameter int TANH_TABLE_POINTS = 256
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input frames
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [TDATA_W-1:0]    req_tdata,    // sample_left [23:0], sample_right [47:24]
   // Result frames
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [TDATA_W-1:0]         rsp_tdata,    // out_left [23:0], out_right [47:24]
   // Register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // Register file. The register is chosen by address bit 2 alone, so the two
   // registers sit at byte addresses 0 and 4.
   logic [DRIVE_W-1:0]  drive_target_ff, drive_target_in;
   logic [LENGTH_W-1:0] ramp_length_ff, ramp_length_in;
   logic                csr_write_w;
   csr_type             cfg_w;

   // Front to queue and queue to back.
   logic      push_valid;
   entry_type push_data;
   logic      queue_full;
   logic      queue_pop;
   entry_type pop_data;
   logic      queue_empty;

   assign csr_pready  = 1'b1;
   assign csr_write_w = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      drive_target_in = drive_target_ff;
      ramp_length_in  = ramp_length_ff;
      if (csr_write_w) begin
         case (csr_reg_type'(csr_paddr[2]))
            REG_DRIVE_TARGET: drive_target_in = csr_pwdata[DRIVE_W-1:0];
            REG_RAMP_LENGTH:  ramp_length_in  = csr_pwdata[LENGTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Reads return the stored value, zero-extended to the bus width.
   always_comb begin
      case (csr_reg_type'(csr_paddr[2]))
         REG_DRIVE_TARGET: csr_prdata = CSR_DATA_W'(drive_target_ff);
         REG_RAMP_LENGTH:  csr_prdata = CSR_DATA_W'(ramp_length_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_target_ff <= '0;
         ramp_length_ff  <= RAMP_LENGTH_RESET;
      end else begin
         drive_target_ff <= drive_target_in;
         ramp_length_ff  <= ramp_length_in;
      end
   end

   assign cfg_w.drive_target = drive_target_ff;
   assign cfg_w.ramp_length  = ramp_length_ff;

   // The front owns the drive ramp: it clamps the target, starts a new ramp
   // when the target moves, steps the drive once per frame and hands the
   // frame on together with the rounded Q1.16 drive.
   sdts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_w),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   sdts_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .queue_full  (queue_full),
      .pop         (queue_pop),
      .pop_data    (pop_data),
      .queue_empty (queue_empty)
   );

   // The back works both channels side by side: table position, lookup and
   // slope, interpolation, blend against the dry sample, then rounding and
   // saturation into the output register.
   sdts_back #(
      .TANH_TABLE_POINTS (TANH_TABLE_POINTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_data    (pop_data),
      .queue_empty (queue_empty),
      .pop         (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // The ramp never leaves the range from no drive to full drive.
   `SDTS_CHECK(a_drive_in_range, clock, reset, push_valid, push_data.drive <= FULL_DRIVE)
   // The queue cannot report full and empty at once.
   `SDTS_CHECK(a_queue_consistent, clock, reset, 1'b1, !(queue_full && queue_empty))
   // After taking a frame the front is not ready again in the next cycle.
   `SDTS_CHECK_NEXT(a_front_busy, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

`default_nettype wire
